// File: rtl/stge_pkg.sv
// ----------------------------------------------------------------------------
// Tone generator package
// Shared widths, register indexes, fixed-point constants and the constant
// tables of the sine polynomial.
// ----------------------------------------------------------------------------
package stge_pkg;

   // Port widths
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;
   localparam int REQ_W     = 8;
   localparam int RSP_W     = 96;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_PER_HZ = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_RATE  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_FREQ   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_START_AMPL   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RAMP_STEP    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TONE_LENGTH  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TONE_PERIOD  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_REPEATS      = 4'd7;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT        = 4'd8;

   // Fixed-point constants
   localparam logic [30:0] MAX31           = 31'h7FFF_FFFF;
   localparam logic [30:0] ONE_Q30         = 31'd1073741824;
   localparam logic [30:0] PI_Q28          = 31'd843314857;
   localparam logic [30:0] TWO_PI_Q28      = 31'd1686629713;
   localparam logic [30:0] HALF_PI_Q28     = 31'd421657428;
   localparam logic [31:0] BLOCK_125US_Q31 = 32'd268435;
   localparam logic [31:0] AMPL_SWEEP_COEF = 32'd1073741824;
   localparam logic [31:0] FREQ_SWEEP_COEF = 32'd1073741824;

   // Reset values of the registers
   localparam logic [17:0] RST_SAMPLE_RATE = 18'd48000;
   localparam logic [30:0] RST_START_FREQ  = 31'd65536000;
   localparam logic [30:0] RST_START_AMPL  = 31'd214748365;

   // Polynomial steps, last index
   localparam logic [2:0] HORNER_LAST = 3'd4;

   // Divisor of each Horner step.
   function automatic logic [6:0] horner_div(input logic [2:0] idx);
      logic [6:0] d;
      case (idx)
         3'd0:    d = 7'd110;
         3'd1:    d = 7'd72;
         3'd2:    d = 7'd42;
         3'd3:    d = 7'd20;
         default: d = 7'd6;
      endcase
      return d;
   endfunction

   // floor(2^32 / divisor): the quotient estimate is low by at most one.
   function automatic logic [31:0] horner_recip(input logic [2:0] idx);
      logic [31:0] m;
      case (idx)
         3'd0:    m = 32'd39045157;
         3'd1:    m = 32'd59652323;
         3'd2:    m = 32'd102261126;
         3'd3:    m = 32'd214748364;
         default: m = 32'd715827882;
      endcase
      return m;
   endfunction

endpackage

// File: rtl/sine_tone_generator_with_envelope_core.sv
// ----------------------------------------------------------------------------
// Sine tone generator with envelope
// One-channel oscillator with a linear fade envelope, tone repeats and
// amplitude and frequency sweeps, computed on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Usage:
// A request on req_ carries one tick bit. A tick of one runs the envelope
// control and yields one response on rsp_ holding the sample, the amplitude
// used for it and the number of completed repeats. A tick of zero is
// accepted and yields nothing.
// The sequencer runs every step through the one registered multiplier,
// mostly the five Horner steps of the sine polynomial (states HA to HD
// each); a tick that starts a new repeat also runs the sweeps and the
// phase step. req_tready is high only while the sequencer is idle, so a
// new tick is not accepted before the last one has left the sequencer.
// A register write on csr_ recomputes the tone set-up in states INIT, STEPF and STEPW.
// The response sits in an output register; a stalled receiver holds it, and
// the next tick is accepted but waits in its last step until that register
// is free. Reset is synchronous: the registers return to their defaults and
// the oscillator and counters clear.
// ----------------------------------------------------------------------------
module sine_tone_generator_with_envelope_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [stge_pkg::REQ_W-1:0]    req_tdata,   // [0] tick, zero fill above
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [stge_pkg::RSP_W-1:0]    rsp_tdata,   // [31:0] sample, [62:32]
                                                      // amplitude_now, [93:63]
                                                      // repeat_index, zero fill
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [stge_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [stge_pkg::CSR_DAT_W-1:0] csr_data
);

   // Sequencer states
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_BLEN  = 5'd1;
   localparam logic [4:0] ST_CTRL  = 5'd2;
   localparam logic [4:0] ST_SWA   = 5'd3;
   localparam logic [4:0] ST_SWA2  = 5'd4;
   localparam logic [4:0] ST_SWF   = 5'd5;
   localparam logic [4:0] ST_SWF2  = 5'd6;
   localparam logic [4:0] ST_INIT  = 5'd7;
   localparam logic [4:0] ST_STEPF = 5'd8;
   localparam logic [4:0] ST_STEPW = 5'd9;
   localparam logic [4:0] ST_SIN0  = 5'd10;
   localparam logic [4:0] ST_SQ    = 5'd11;
   localparam logic [4:0] ST_X2    = 5'd12;
   localparam logic [4:0] ST_HA    = 5'd13;
   localparam logic [4:0] ST_HB    = 5'd14;
   localparam logic [4:0] ST_HC    = 5'd15;
   localparam logic [4:0] ST_HD    = 5'd16;
   localparam logic [4:0] ST_FIN   = 5'd17;
   localparam logic [4:0] ST_FS    = 5'd18;
   localparam logic [4:0] ST_MULS  = 5'd19;
   localparam logic [4:0] ST_SMP   = 5'd20;

   logic [4:0]  state_ff, state_in;

   // Configuration registers
   logic [30:0] pph_ff, pph_in;
   logic [17:0] sr_ff, sr_in;
   logic [30:0] sfreq_ff, sfreq_in;
   logic [30:0] sampl_ff, sampl_in;
   logic [30:0] ramp_ff, ramp_in;
   logic [30:0] tlen_ff, tlen_in;
   logic [30:0] tper_ff, tper_in;
   logic [30:0] reps_ff, reps_in;

   // Tone state
   logic [30:0] phase_ff, phase_in;
   logic [29:0] step_ff, step_in;
   logic [30:0] amp_ff, amp_in;
   logic [30:0] tgt_ff, tgt_in;
   logic [30:0] freq_ff, freq_in;
   logic [15:0] sbc_ff, sbc_in;
   logic [30:0] bc_ff, bc_in;
   logic [30:0] rc_ff, rc_in;
   logic        init_ff, init_in;

   // Sine working registers
   logic [30:0] x30_ff, x30_in;
   logic        neg_ff, neg_in;
   logic [31:0] x2_ff, x2_in;
   logic [30:0] t_ff, t_in;
   logic [31:0] v_ff, v_in;
   logic [31:0] q_ff, q_in;
   logic [2:0]  hi_ff, hi_in;
   logic [30:0] s_ff, s_in;

   // Shared multiplier
   logic        mul_en;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_ff;

   // Output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [stge_pkg::RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   // Derived values
   logic [7:0]  blen_w;
   logic [15:0] sbc_inc;
   logic        blk_end;
   logic [30:0] bc_inc;
   logic [30:0] fmax;
   logic [31:0] ramp_sum;
   logic [31:0] ramp_lim;
   logic [35:0] swp_r;
   logic [30:0] swp_sat;
   logic [46:0] stw_r;
   logic [29:0] stw_sat;
   logic [30:0] red_a0, red_a1, red_a2;
   logic        red_neg;
   logic [31:0] hd_rem;
   logic [31:0] hd_q;
   logic [31:0] hd_t;
   logic [62:0] smag_sum;
   logic [31:0] smag;
   logic [31:0] sample;
   logic [31:0] ph_sum;
   logic        out_free;
   logic        req_acc, csr_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE) && !req_tvalid;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_acc    = csr_valid && csr_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Block length, rounded, and block bookkeeping
   assign blen_w  = {1'b0, prod_ff[36:30]} + 8'd1;
   assign sbc_inc = sbc_ff + 16'd1;
   assign blk_end = (sbc_inc >= {9'd0, blen_w[7:1]});
   assign bc_inc  = (bc_ff == stge_pkg::MAX31) ? bc_ff : bc_ff + 31'd1;

   // Nyquist limit, Q16.16
   assign fmax = (sr_ff[17:16] != 2'd0) ? stge_pkg::MAX31 : {sr_ff[15:0], 15'd0};

   // Ramp arithmetic
   assign ramp_sum = {1'b0, amp_ff} + {1'b0, ramp_ff};
   assign ramp_lim = {1'b0, ramp_ff} + {1'b0, tgt_ff};

   // Sweep product rounded from Q2.30 scaling and saturated
   assign swp_r   = {1'b0, prod_ff[63:29]} + 36'd1;
   assign swp_sat = (swp_r[35:1] > {4'd0, stge_pkg::MAX31}) ? stge_pkg::MAX31
                                                          : swp_r[31:1];

   // Phase step rounded and limited to pi
   assign stw_r   = {1'b0, prod_ff[63:18]} + 47'd1;
   assign stw_sat = (stw_r[46:1] > {15'd0, stge_pkg::PI_Q28}) ?
                    stge_pkg::PI_Q28[29:0] : stw_r[30:1];

   // Quadrant reduction of the phase
   assign red_a0  = (phase_ff >= stge_pkg::TWO_PI_Q28) ?
                    phase_ff - stge_pkg::TWO_PI_Q28 : phase_ff;
   assign red_neg = (red_a0 > stge_pkg::PI_Q28);
   assign red_a1  = red_neg ? red_a0 - stge_pkg::PI_Q28 : red_a0;
   assign red_a2  = (red_a1 > stge_pkg::HALF_PI_Q28) ?
                    stge_pkg::PI_Q28 - red_a1 : red_a1;

   // Quotient correction of one Horner step
   assign hd_rem = v_ff - prod_ff[31:0];
   assign hd_q   = (hd_rem >= {25'd0, stge_pkg::horner_div(hi_ff)}) ? q_ff + 32'd1 : q_ff;
   assign hd_t   = {1'b0, stge_pkg::ONE_Q30} - hd_q;

   // Sample: floor for positive, ceiling magnitude for negative
   assign smag_sum = {1'b0, prod_ff[61:0]} + {32'd0, stge_pkg::MAX31};
   assign smag     = neg_ff ? smag_sum[62:31] : prod_ff[62:31];
   assign sample   = neg_ff ? (32'd0 - smag) : smag;

   // Phase advance with wrap at two pi
   assign ph_sum = {1'b0, phase_ff} + {2'd0, step_ff};

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      pph_in       = pph_ff;
      sr_in        = sr_ff;
      sfreq_in     = sfreq_ff;
      sampl_in     = sampl_ff;
      ramp_in      = ramp_ff;
      tlen_in      = tlen_ff;
      tper_in      = tper_ff;
      reps_in      = reps_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      amp_in       = amp_ff;
      tgt_in       = tgt_ff;
      freq_in      = freq_ff;
      sbc_in       = sbc_ff;
      bc_in        = bc_ff;
      rc_in        = rc_ff;
      init_in      = init_ff;
      x30_in       = x30_ff;
      neg_in       = neg_ff;
      x2_in        = x2_ff;
      t_in         = t_ff;
      v_in         = v_ff;
      q_in         = q_ff;
      hi_in        = hi_ff;
      s_in         = s_ff;
      mul_en       = 1'b0;
      mul_a        = 32'd0;
      mul_b        = 32'd0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tdata[0]) begin
               state_in = ST_BLEN;
            end else if (csr_acc && (csr_index < stge_pkg::REG_COUNT)) begin
               state_in = ST_INIT;
               case (csr_index)
                  stge_pkg::REG_PHASE_PER_HZ: pph_in   = csr_data[30:0];
                  stge_pkg::REG_SAMPLE_RATE:  sr_in    = csr_data[17:0];
                  stge_pkg::REG_START_FREQ:   sfreq_in = csr_data[30:0];
                  stge_pkg::REG_START_AMPL:   sampl_in = csr_data[30:0];
                  stge_pkg::REG_RAMP_STEP:    ramp_in  = csr_data[30:0];
                  stge_pkg::REG_TONE_LENGTH:  tlen_in  = csr_data[30:0];
                  stge_pkg::REG_TONE_PERIOD:  tper_in  = csr_data[30:0];
                  default:                    reps_in  = csr_data[30:0];
               endcase
            end
         end
         ST_BLEN: begin
            mul_en   = 1'b1;
            mul_a    = {14'd0, sr_ff};
            mul_b    = stge_pkg::BLOCK_125US_Q31;
            state_in = ST_CTRL;
         end
         ST_CTRL: begin
            state_in = ST_SIN0;
            if (!blk_end) begin
               sbc_in = sbc_inc;
            end else begin
               sbc_in = 16'd0;
               bc_in  = bc_inc;
               // Ramp toward the target, up or down, while the tone is on
               if (bc_inc < tlen_ff) begin
                  if (amp_ff == 31'd0) begin
                     phase_in = 31'd0;
                  end
                  if (amp_ff > tgt_ff) begin
                     amp_in = ({1'b0, amp_ff} < ramp_lim) ? tgt_ff : amp_ff - ramp_ff;
                  end else begin
                     amp_in = (ramp_sum > {1'b0, tgt_ff}) ? tgt_ff : ramp_sum[30:0];
                  end
               end else if (bc_inc > tlen_ff) begin
                  // Fade-out toward zero
                  amp_in = (amp_ff < ramp_ff) ? 31'd0 : amp_ff - ramp_ff;
               end
               // Start of a new repeat
               if ((bc_inc > tper_ff) &&
                   (({1'b0, rc_ff} + 32'd1) < {1'b0, reps_ff})) begin
                  bc_in    = 31'd0;
                  rc_in    = rc_ff + 31'd1;
                  state_in = ST_SWA;
               end
            end
         end
         ST_SWA: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, tgt_ff};
            mul_b    = stge_pkg::AMPL_SWEEP_COEF;
            state_in = ST_SWA2;
         end
         ST_SWA2: begin
            tgt_in   = swp_sat;
            amp_in   = (ramp_ff > swp_sat) ? swp_sat : ramp_ff;
            state_in = ST_SWF;
         end
         ST_SWF: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, freq_ff};
            mul_b    = stge_pkg::FREQ_SWEEP_COEF;
            state_in = ST_SWF2;
         end
         ST_SWF2: begin
            freq_in  = (swp_sat > fmax) ? fmax : swp_sat;
            init_in  = 1'b0;
            state_in = ST_STEPF;
         end
         ST_INIT: begin
            tgt_in   = sampl_ff;
            amp_in   = (ramp_ff > sampl_ff) ? sampl_ff : ramp_ff;
            freq_in  = (sfreq_ff > fmax) ? fmax : sfreq_ff;
            init_in  = 1'b1;
            state_in = ST_STEPF;
         end
         ST_STEPF: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, freq_ff};
            mul_b    = {1'b0, pph_ff};
            state_in = ST_STEPW;
         end
         ST_STEPW: begin
            step_in  = stw_sat;
            state_in = init_ff ? ST_IDLE : ST_SIN0;
         end
         ST_SIN0: begin
            x30_in   = {red_a2[28:0], 2'b00};
            neg_in   = red_neg;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, x30_ff};
            mul_b    = {1'b0, x30_ff};
            state_in = ST_X2;
         end
         ST_X2: begin
            x2_in    = prod_ff[61:30];
            t_in     = stge_pkg::ONE_Q30;
            hi_in    = 3'd0;
            state_in = ST_HA;
         end
         ST_HA: begin
            mul_en   = 1'b1;
            mul_a    = x2_ff;
            mul_b    = {1'b0, t_ff};
            state_in = ST_HB;
         end
         ST_HB: begin
            // Quotient estimate through the reciprocal
            v_in     = prod_ff[61:30];
            mul_en   = 1'b1;
            mul_a    = prod_ff[61:30];
            mul_b    = stge_pkg::horner_recip(hi_ff);
            state_in = ST_HC;
         end
         ST_HC: begin
            q_in     = prod_ff[63:32];
            mul_en   = 1'b1;
            mul_a    = prod_ff[63:32];
            mul_b    = {25'd0, stge_pkg::horner_div(hi_ff)};
            state_in = ST_HD;
         end
         ST_HD: begin
            t_in = hd_t[30:0];
            if (hi_ff == stge_pkg::HORNER_LAST) begin
               state_in = ST_FIN;
            end else begin
               hi_in    = hi_ff + 3'd1;
               state_in = ST_HA;
            end
         end
         ST_FIN: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, x30_ff};
            mul_b    = {1'b0, t_ff};
            state_in = ST_FS;
         end
         ST_FS: begin
            s_in     = (|prod_ff[63:60]) ? stge_pkg::MAX31 : {prod_ff[59:30], 1'b0};
            state_in = ST_MULS;
         end
         ST_MULS: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, s_ff};
            mul_b    = {1'b0, amp_ff};
            state_in = ST_SMP;
         end
         ST_SMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, rc_ff, amp_ff, sample};
               phase_in     = (ph_sum > {1'b0, stge_pkg::TWO_PI_Q28}) ?
                              ph_sum[30:0] - stge_pkg::TWO_PI_Q28 : ph_sum[30:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Multiplier output register
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // Working registers without reset
   always_ff @(posedge clock) begin
      x30_ff      <= x30_in;
      neg_ff      <= neg_in;
      x2_ff       <= x2_in;
      t_ff        <= t_in;
      v_ff        <= v_in;
      q_ff        <= q_in;
      hi_ff       <= hi_in;
      s_ff        <= s_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Control, configuration and tone state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pph_ff       <= 31'd0;
         sr_ff        <= stge_pkg::RST_SAMPLE_RATE;
         sfreq_ff     <= stge_pkg::RST_START_FREQ;
         sampl_ff     <= stge_pkg::RST_START_AMPL;
         ramp_ff      <= stge_pkg::MAX31;
         tlen_ff      <= stge_pkg::MAX31;
         tper_ff      <= stge_pkg::MAX31;
         reps_ff      <= 31'd0;
         phase_ff     <= 31'd0;
         step_ff      <= 30'd0;
         amp_ff       <= 31'd0;
         tgt_ff       <= stge_pkg::RST_START_AMPL;
         freq_ff      <= stge_pkg::RST_START_FREQ;
         sbc_ff       <= 16'd0;
         bc_ff        <= 31'd0;
         rc_ff        <= 31'd0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pph_ff       <= pph_in;
         sr_ff        <= sr_in;
         sfreq_ff     <= sfreq_in;
         sampl_ff     <= sampl_in;
         ramp_ff      <= ramp_in;
         tlen_ff      <= tlen_in;
         tper_ff      <= tper_in;
         reps_ff      <= reps_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         amp_ff       <= amp_in;
         tgt_ff       <= tgt_in;
         freq_ff      <= freq_in;
         sbc_ff       <= sbc_in;
         bc_ff        <= bc_in;
         rc_ff        <= rc_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/stge_checker.sv
// ----------------------------------------------------------------------------
// Tone generator port checker
// Watches the ports of the tone generator over time.
// ----------------------------------------------------------------------------
module stge_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [stge_pkg::REQ_W-1:0]     req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [stge_pkg::RSP_W-1:0]     rsp_tdata,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [stge_pkg::CSR_IDX_W-1:0] csr_index
);

   // A stalled response stays and holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A tick request keeps the block busy in the next cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[0] |=> !req_tready && !csr_ready)
      else $error("block ready right after a tick request");

   // A register write in range starts the set-up sequence.
   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index < stge_pkg::REG_COUNT) |=> !req_tready)
      else $error("block ready right after a register write");

   // A zero amplitude gives a silent sample.
   a_zero_amp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[62:32] == 31'd0) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("sample not zero at zero amplitude");

endmodule

bind sine_tone_generator_with_envelope_core stge_checker u_stge_checker (.*);
